// ----- src/csm_pkg.sv -----
// ---------------------------------------------------------------------------
// csm_pkg: shared types, constants and helpers for the caseless substring match
// Holds the pattern layout, the register indexes and the ASCII case folding.
// ---------------------------------------------------------------------------
package csm_pkg;

  // Width of one text byte.
  localparam int BYTE_W = 8;
  // Pattern storage: two 64-bit registers give sixteen bytes.
  localparam int PAT_BYTES = 16;
  localparam int PAT_IDX_W = 4;
  localparam int LEN_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 2;
  // Width for position and length arithmetic; covers positions up to 127.
  localparam int IDX_W = 7;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  // ASCII letter bounds and the distance between the cases.
  localparam logic [BYTE_W-1:0] LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_GAP = 8'h20;

  typedef logic [BYTE_W-1:0] text_byte_t;
  typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern_t;

  // Fold a lower-case ASCII letter to upper case; every other code passes.
  function automatic text_byte_t fold_upper(text_byte_t c);
    if (c >= LOWER_A && c <= LOWER_Z) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

  // Pattern byte that must sit at window position pos for a match ending now.
  // Positions beyond the stored sixteen bytes read as zero.
  function automatic text_byte_t pattern_at(pattern_t pat, logic [LEN_W-1:0] len,
                                            logic [IDX_W-1:0] pos);
    logic [IDX_W-1:0] idx;
    idx = IDX_W'(len) - pos - IDX_W'(1);
    if (idx < IDX_W'(PAT_BYTES)) begin
      return pat[idx[PAT_IDX_W-1:0]];
    end
    return '0;
  endfunction

endpackage

// ----- src/csm_cell.sv -----
// ---------------------------------------------------------------------------
// csm_cell: one window cell of the substring matcher
// Holds one folded text byte, passes it to the next cell on every shift and
// checks it against the pattern byte that belongs to its window position.
// ---------------------------------------------------------------------------
module csm_cell
  import csm_pkg::*;
#(
  parameter int POS = 1
) (
  input  logic             clk,
  input  logic             shift_en,
  input  text_byte_t       byte_in,
  input  pattern_t         pattern,
  input  logic [LEN_W-1:0] pattern_length,
  output text_byte_t       byte_out,
  output logic             pos_ok
);

  text_byte_t held;
  logic       active;

  // Take the neighbor's byte whenever the window advances.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;

  // This position takes part only when the pattern reaches back this far.
  assign active = IDX_W'(pattern_length) > IDX_W'(POS);
  assign pos_ok = !active || (held == pattern_at(pattern, pattern_length, IDX_W'(POS)));

endmodule

// ----- src/caseless_substring_match.sv -----
// ---------------------------------------------------------------------------
// caseless_substring_match: per-record case-insensitive pattern search
// Scans record text one byte per item and reports, on each record's last
// byte, whether the configured pattern appeared anywhere in that record.
// ---------------------------------------------------------------------------
// Usage:
//   Write the pattern bytes and pattern length through the configuration
//   port (cfg_write_en, cfg_index, cfg_data) while no result is pending.
//   Text enters on the in channel (record_byte, record_end) with valid and
//   ready; one item is taken per cycle, back to back, while in_ready is high.
//   Each item whose record_end is set produces one item on the out channel
//   (record_matched) in the cycle after it is accepted; other items produce none.
//   The window is the incoming byte plus one cell per earlier pattern position;
//   all positions compare in parallel, one byte per clock while in_ready is high.
//   The result sits in an output register; when the receiver stalls with a
//   result pending, in_ready drops until that result is taken.
//   Reset clears the pattern registers, the byte count, the hit flag and the
//   output valid; the block takes items in the first cycle after reset.
// ---------------------------------------------------------------------------
module caseless_substring_match
  import csm_pkg::*;
#(
  parameter int PATTERN_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     record_byte,
  input  logic                  record_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  record_matched
);

  localparam int CNT_W = $clog2(PATTERN_MAX + 1);

  logic [CFG_DATA_W-1:0]  pattern_bytes_low;
  logic [CFG_DATA_W-1:0]  pattern_bytes_high;
  logic [LEN_W-1:0]       pattern_length;
  pattern_t               pattern;
  logic [CNT_W-1:0]       bytes_in_record;
  logic [CNT_W-1:0]       count_now;
  logic                   seen_match;
  logic                   accept;
  logic                   hit;
  logic                   match_now;
  logic                   len_fits;
  logic                   enough_bytes;
  text_byte_t             cur;
  text_byte_t             window [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] pos_ok;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low <= '0;
      pattern_bytes_high <= '0;
      pattern_length <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pattern_bytes_low <= cfg_data;
        REG_PATTERN_HIGH:   pattern_bytes_high <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Folded pattern bytes, byte 0 of the low register first.
  always_comb begin
    for (int i = 0; i < PAT_BYTES / 2; i++) begin
      pattern[i] = fold_upper(pattern_bytes_low[i*BYTE_W +: BYTE_W]);
      pattern[i + PAT_BYTES / 2] = fold_upper(pattern_bytes_high[i*BYTE_W +: BYTE_W]);
    end
  end

  assign accept = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign cur = fold_upper(record_byte);

  // Position zero is the incoming byte itself.
  assign window[0] = cur;
  assign pos_ok[0] = (cur == pattern_at(pattern, pattern_length, '0));

  // Row of cells holding the earlier bytes, newest first.
  for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_cell
    csm_cell #(
      .POS(k)
    ) u_cell (
      .clk           (clk),
      .shift_en      (accept && !record_end),
      .byte_in       (window[k-1]),
      .pattern       (pattern),
      .pattern_length(pattern_length),
      .byte_out      (window[k]),
      .pos_ok        (pos_ok[k])
    );
  end

  // Byte count including the current byte, saturating at the window depth.
  assign count_now = (bytes_in_record == CNT_W'(PATTERN_MAX)) ? bytes_in_record
                                                               : bytes_in_record + CNT_W'(1);

  // A match ends here if the pattern is empty, or if it fits, enough bytes are in and every active position agrees.
  assign len_fits = IDX_W'(pattern_length) <= IDX_W'(PATTERN_MAX);
  assign enough_bytes = IDX_W'(count_now) >= IDX_W'(pattern_length);
  assign match_now = (pattern_length == '0) || (len_fits && enough_bytes && (&pos_ok));
  assign hit = seen_match || match_now;

  // Per-record state: cleared on the last byte of each record.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_record <= '0;
      seen_match <= 1'b0;
    end else if (accept) begin
      if (record_end) begin
        bytes_in_record <= '0;
        seen_match <= 1'b0;
      end else begin
        bytes_in_record <= count_now;
        seen_match <= hit;
      end
    end
  end

  // Output register for the per-record result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && record_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && record_end) begin
      record_matched <= hit;
    end
  end

  // The last byte of a record leaves the per-record state cleared.
  a_record_clears : assert property (@(posedge clk) disable iff (rst)
    accept && record_end |=> bytes_in_record == '0 && !seen_match)
    else $error("per-record state not cleared after last byte");

  // The byte count saturates at the window depth.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    bytes_in_record <= CNT_W'(PATTERN_MAX))
    else $error("byte count beyond window depth");

  // An empty pattern reports a match for every record.
  a_empty_pattern : assert property (@(posedge clk) disable iff (rst)
    accept && record_end && pattern_length == '0 |=> out_valid && record_matched)
    else $error("empty pattern did not match");

  // A latched hit always comes from a byte of the current record.
  a_hit_needs_bytes : assert property (@(posedge clk) disable iff (rst)
    seen_match |-> bytes_in_record != '0)
    else $error("hit latched with no bytes in record");

endmodule

// ----- test/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: testbench for caseless_substring_match
// Streams record text through the block and checks every per-record result
// against a scoreboard model of the case-insensitive pattern search. It
// covers directed cases first: empty pattern, short records, case folding,
// full and over-long patterns, and updates in the middle of a record.
// Then it runs random pattern settings with records of which about half carry
// the pattern. Both handshake sides idle at random.
// ---------------------------------------------------------------------------
module tb_top
  import csm_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATTERN_MAX = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  logic                  clk;
  logic                  rst;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [BYTE_W-1:0]     record_byte;
  logic                  record_end;
  logic                  out_valid;
  logic                  out_ready;
  logic                  record_matched;

  // Pattern registers as the scoreboard sees them.
  logic [63:0]           pat_lo;
  logic [63:0]           pat_hi;
  logic [LEN_W-1:0]      pat_len;

  // Scan state of the scoreboard model: earlier folded bytes, newest first.
  logic [BYTE_W-1:0]     prior_bytes[PATTERN_MAX-1];
  int                    record_count;
  bit                    hit_latched;

  // Match flags still owed by the block, oldest first.
  bit                    expected_matches[$];

  bit                    in_burst;
  bit                    out_burst;
  bit                    want_match;
  int                    errors;
  int                    cycle_count;
  int                    bytes_sent;
  int                    random_bytes;
  int                    records_checked;
  int                    matched_records;
  int                    settings_used;

  caseless_substring_match #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .record_byte(record_byte),
    .record_end(record_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .record_matched(record_matched)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ASCII helpers for the model and for building text.
  function automatic logic [BYTE_W-1:0] to_upper(logic [BYTE_W-1:0] c);
    if (c >= LOWER_A && c <= LOWER_Z) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] swap_case(logic [BYTE_W-1:0] c);
    if ((c >= LOWER_A && c <= LOWER_Z) || (c >= 8'h41 && c <= 8'h5A)) begin
      return c ^ CASE_GAP;
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_byte(int i);
    if (i < 8) begin
      return pat_lo[8*i +: 8];
    end
    if (i < 16) begin
      return pat_hi[8*(i-8) +: 8];
    end
    return '0;
  endfunction

  // True when the pattern ends at the current byte of the record.
  function automatic bit pattern_ends_here(logic [BYTE_W-1:0] cur, int count_now);
    int len;
    int k;
    logic [BYTE_W-1:0] have;
    len = pat_len;
    if (len == 0) begin
      return 1'b1;
    end
    if (len > PATTERN_MAX || count_now < len) begin
      return 1'b0;
    end
    for (int i = 0; i < len; i++) begin
      k = len - 1 - i;
      have = (k == 0) ? cur : prior_bytes[k-1];
      if (to_upper(pattern_byte(i)) != have) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Advance the model by one accepted byte; a last byte owes one result.
  function automatic void advance_scan(logic [BYTE_W-1:0] b, logic last);
    logic [BYTE_W-1:0] cur;
    int count_now;
    bit hit;
    cur = to_upper(b);
    count_now = (record_count + 1 > PATTERN_MAX) ? PATTERN_MAX : record_count + 1;
    hit = hit_latched || pattern_ends_here(cur, count_now);
    if (last) begin
      expected_matches = {expected_matches, hit};
      foreach (prior_bytes[i]) prior_bytes[i] = '0;
      record_count = 0;
      hit_latched = 1'b0;
    end else begin
      for (int k = PATTERN_MAX - 2; k > 0; k--) begin
        prior_bytes[k] = prior_bytes[k-1];
      end
      prior_bytes[0] = cur;
      record_count = count_now;
      hit_latched = hit;
    end
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= REPORT_MAX) begin
      $display("ERROR: %s", msg);
    end
  endtask

  // Send one text byte; called and returns at a falling edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    record_byte <= b;
    record_end <= last;
    do @(posedge clk); while (!in_ready);
    advance_scan(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_record(input byte_q_t text);
    in_burst = ($urandom_range(0, 3) == 0);
    foreach (text[i]) begin
      send_byte(text[i], i == text.size() - 1);
    end
  endtask

  // Hold the sender until every owed result has come and the block is quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all three pattern registers; the block must be idle.
  task automatic program_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [LEN_W-1:0] len);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_PATTERN_LOW;
    cfg_data <= lo;
    @(negedge clk);
    cfg_index <= REG_PATTERN_HIGH;
    cfg_data <= hi;
    @(negedge clk);
    // Bits above the length field are don't-care and get random values.
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_data <= {$urandom, 27'($urandom), len};
    @(negedge clk);
    cfg_write_en <= 1'b0;
    pat_lo = lo;
    pat_hi = hi;
    pat_len = len;
    settings_used++;
  endtask

  // Reset state: an empty pattern matches every record, even the byte extremes.
  task automatic test_empty_pattern();
    send_record('{8'h00});
    send_record('{8'hFF, 8'h61});
  endtask

  // A zero pattern must not match a record shorter than it, whatever the window holds.
  task automatic test_short_record();
    drain_results();
    program_pattern(64'h0, 64'h0, 5'd2);
    send_record('{8'h00});
    send_record('{8'h00, 8'h00});
  endtask

  // Only letters fold; the codes next to the letters stay distinct.
  task automatic test_case_folding();
    drain_results();
    program_pattern(64'h605A61, 64'h0, 5'd3);
    send_record('{8'h41, 8'h7A, 8'h40});
    send_record('{8'h41, 8'h5A, 8'h60});
  endtask

  // Sixteen-byte pattern with byte extremes, sent with letters case-swapped.
  task automatic test_full_length();
    byte_q_t text;
    drain_results();
    program_pattern(64'h8060407B5A61FF00, 64'h3C5BFE017A41207F, 5'd16);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      text = {text, swap_case(pattern_byte(i))};
    end
    send_record(text);
  endtask

  // Lengths beyond the pattern storage never match.
  task automatic test_overlong_pattern();
    drain_results();
    program_pattern(64'h0, 64'h0, 5'd17);
    send_record('{8'h00});
    drain_results();
    program_pattern(64'h0, 64'h0, 5'd31);
    send_record('{8'h00});
  endtask

  // Updates between bytes of a record: earlier hits stay latched and the
  // window keeps the bytes seen before the update.
  task automatic test_mid_record_update();
    drain_results();
    program_pattern(64'h51, 64'h0, 5'd1);
    send_byte(8'h71, 1'b0);
    drain_results();
    program_pattern(64'h5A5A5A, 64'h0, 5'd3);
    send_byte(8'h41, 1'b1);
    send_byte(8'h51, 1'b0);
    drain_results();
    program_pattern(64'h5251, 64'h0, 5'd2);
    send_byte(8'h72, 1'b1);
  endtask

  // Text byte: either drawn from the pattern, case-swapped at random, or noise.
  function automatic logic [BYTE_W-1:0] filler_byte(bit noise);
    int plen;
    logic [BYTE_W-1:0] b;
    plen = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    if (noise || plen == 0 || $urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    b = pattern_byte($urandom_range(0, plen - 1));
    return $urandom_range(0, 1) ? swap_case(b) : b;
  endfunction

  // Random records: about half carry the pattern, some a near miss, the rest
  // pattern fragments or plain noise.
  task automatic send_random_record();
    byte_q_t text;
    int style;
    int plen;
    int miss;
    logic [BYTE_W-1:0] b;
    style = $urandom_range(0, 9);
    plen = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    repeat ($urandom_range(0, 12)) text = {text, filler_byte(style >= 8)};
    if (style < 6 && plen > 0) begin
      miss = (style == 5) ? $urandom_range(0, plen - 1) : -1;
      for (int i = 0; i < plen; i++) begin
        b = pattern_byte(i);
        if ($urandom_range(0, 1)) b = swap_case(b);
        if (i == miss) b = b + 8'd1;
        text = {text, b};
      end
    end
    repeat ($urandom_range(0, 12)) text = {text, filler_byte(style >= 8)};
    if (text.size() == 0) begin
      text = {text, filler_byte(1'b0)};
    end
    send_record(text);
    random_bytes += text.size();
  endtask

  task automatic test_random_text();
    logic [127:0] pat;
    logic [LEN_W-1:0] len;
    bit letters;
    while (random_bytes < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: len = 5'd0;
        1: len = 5'd16;
        2: len = 5'd1;
        3: len = 5'($urandom_range(17, 31));
        default: len = 5'($urandom_range(2, 15));
      endcase
      // Letter-heavy patterns exercise folding; others use any byte value.
      letters = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < 16; i++) begin
        if (letters && $urandom_range(0, 3) != 0) begin
          pat[8*i +: 8] = 8'(8'h41 + $urandom_range(0, 25)) |
                          ($urandom_range(0, 1) ? CASE_GAP : 8'h00);
        end else begin
          pat[8*i +: 8] = 8'($urandom_range(0, 255));
        end
      end
      drain_results();
      program_pattern(pat[63:0], pat[127:64], len);
      repeat ($urandom_range(8, 30)) send_random_record();
      // Sometimes leave a record open so the next setting lands mid-record.
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          send_byte(filler_byte(1'b0), 1'b0);
          random_bytes++;
        end
      end
    end
  endtask

  // Result checker: each accepted result against the oldest owed flag.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      records_checked++;
      if (record_matched === 1'b1) matched_records++;
      if (expected_matches.size() == 0) begin
        flag_error($sformatf("unexpected result record_matched=%0b", record_matched));
      end else begin
        want_match = expected_matches.pop_front();
        if (record_matched !== want_match) begin
          flag_error($sformatf("record %0d: expected record_matched=%0b, got %0b",
                               records_checked, want_match, record_matched));
        end
      end
    end
  end

  // Receiver: stalls at random before taking each result, but not in bursts.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 7) == 0) out_burst = !out_burst;
      @(negedge clk);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = REG_PATTERN_LOW;
    cfg_data = '0;
    in_valid = 1'b0;
    record_byte = '0;
    record_end = 1'b0;
    pat_lo = '0;
    pat_hi = '0;
    pat_len = '0;
    foreach (prior_bytes[i]) prior_bytes[i] = '0;
    record_count = 0;
    hit_latched = 1'b0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    errors = 0;
    cycle_count = 0;
    bytes_sent = 0;
    random_bytes = 0;
    records_checked = 0;
    matched_records = 0;
    settings_used = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_pattern();
    test_short_record();
    test_case_folding();
    test_full_length();
    test_overlong_pattern();
    test_mid_record_update();
    test_random_text();

    drain_results();
    repeat (8) @(negedge clk);
    $display("Scanned %0d text bytes over %0d pattern settings.", bytes_sent, settings_used);
    $display("Checked %0d records, %0d of them reported a match.",
             records_checked, matched_records);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- caseless_substring_match.f -----
src/csm_pkg.sv
src/csm_cell.sv
src/caseless_substring_match.sv
test/tb_top.sv
